>>> rtl/assert_macros.svh
// Assertion macros shared by the descriptor builder RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> rtl/ctdb_pkg.sv
// Types, constants and helpers for the control transfer descriptor builder.
// No dependencies; imported by every ctdb module.
package ctdb_pkg;

   localparam int SETUP_BYTES = 8;

   // Token PIDs
   localparam logic [7:0] PID_SETUP = 8'h2D;
   localparam logic [7:0] PID_IN    = 8'h69;
   localparam logic [7:0] PID_OUT   = 8'hE1;

   // Length field of a zero-length packet
   localparam logic [10:0] LEN_ZERO = 11'h7FF;

   // Status word pieces
   localparam logic [31:0] STATUS_BASE      = (32'd1 << 23) | (32'd3 << 27);
   localparam logic [31:0] STATUS_LOW_SPEED = 32'd1 << 26;

   // Request queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // One classified request
   typedef struct packed {
      logic [6:0]  addr;
      logic [7:0]  data_pid;
      logic [7:0]  stat_pid;
      logic [31:0] status;
      logic [8:0]  length;
      logic [6:0]  mp;
      logic [31:0] setup_buf;
      logic [31:0] data_buf;
   } ctdb_entry_type;

   // Queue status seen by the front and back
   typedef struct packed {
      logic not_empty;
      logic not_full;
   } ctdb_qstat_type;

   // Back-end sequencer
   typedef enum logic [1:0] {
      S_IDLE,
      S_SETUP,
      S_DATA,
      S_STATUS
   } ctdb_state_type;

   // Header word: PID, address, endpoint 0, toggle, length minus one
   function automatic logic [31:0] make_header(input logic [7:0]  pid,
                                               input logic [6:0]  addr,
                                               input logic [10:0] len_m1,
                                               input logic        toggle);
      make_header = {len_m1, 1'b0, toggle, 4'b0000, addr, pid};
   endfunction

endpackage

>>> rtl/ctdb_front.sv
// Front end: accepts a request, classifies it and hands it to the queue.
// Depends on ctdb_pkg.
module ctdb_front
   import ctdb_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  logic [6:0]     req_device_address,
   input  logic           req_low_speed,
   input  logic           req_device_to_host,
   input  logic [8:0]     req_data_length,
   input  logic [31:0]    req_setup_buffer_addr,
   input  logic [31:0]    req_data_buffer_addr,
   input  logic [6:0]     pkt_size,
   input  ctdb_qstat_type qstat,
   output logic           push,
   output ctdb_entry_type push_entry
);

   logic           vld_ff, vld_in;
   ctdb_entry_type ent_ff, ent_in;
   logic           take;

   // Hold one classified request until the queue has room
   assign push      = vld_ff && qstat.not_full;
   assign req_stall = vld_ff && !qstat.not_full;
   assign take      = req_valid && !req_stall;
   assign push_entry = ent_ff;

   // Classification
   always_comb begin
      ent_in           = ent_ff;
      vld_in           = vld_ff && !push;
      if (take) begin
         vld_in           = 1'b1;
         ent_in.addr      = req_device_address;
         ent_in.data_pid  = req_device_to_host ? PID_IN : PID_OUT;
         ent_in.stat_pid  = req_device_to_host ? PID_OUT : PID_IN;
         ent_in.status    = STATUS_BASE | (req_low_speed ? STATUS_LOW_SPEED : 32'd0);
         ent_in.length    = req_data_length;
         ent_in.mp        = (pkt_size == 7'd0) ? 7'd1 : pkt_size;
         ent_in.setup_buf = req_setup_buffer_addr;
         ent_in.data_buf  = req_data_buffer_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      ent_ff <= ent_in;
   end

endmodule

>>> rtl/ctdb_queue.sv
// Short request queue between the front and back ends.
// Depends on ctdb_pkg and assert_macros.svh.
module ctdb_queue
   import ctdb_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  ctdb_entry_type push_entry,
   input  logic           pop,
   output ctdb_entry_type pop_entry,
   output ctdb_qstat_type qstat
);
`include "assert_macros.svh"

   ctdb_entry_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]         count_ff, count_in;

   assign qstat.not_empty = (count_ff != '0);
   assign qstat.not_full  = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign pop_entry       = mem_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `ASSERT_NEVER(a_no_push_full, clock, reset, push && !qstat.not_full, "push into full queue")
   `ASSERT_NEVER(a_no_pop_empty, clock, reset, pop && !qstat.not_empty, "pop from empty queue")

endmodule

>>> rtl/ctdb_back.sv
// Back end: walks one request through SETUP, data and status descriptors.
// Depends on ctdb_pkg and assert_macros.svh.
module ctdb_back
   import ctdb_pkg::*;
#(
   parameter int MAX_DESCRIPTORS = 64
)
(
   input  logic           clock,
   input  logic           reset,
   input  ctdb_qstat_type qstat,
   input  ctdb_entry_type pop_entry,
   output logic           pop,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic [5:0]     rsp_descriptor_index,
   output logic [31:0]    rsp_header_word,
   output logic [31:0]    rsp_status_word,
   output logic [31:0]    rsp_buffer_word,
   output logic           rsp_last
);
`include "assert_macros.svh"

   // Data descriptors stop once the index reaches this value
   localparam logic [6:0] DATA_LIMIT = 7'(MAX_DESCRIPTORS - 1);

   ctdb_state_type state_ff, state_in;
   ctdb_entry_type ent_ff, ent_in;
   logic [5:0]     k_ff, k_in;
   logic [8:0]     rem_ff, rem_in;
   logic [31:0]    buf_ff, buf_in;
   logic           tog_ff, tog_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [5:0]     rsp_index_ff, rsp_index_in;
   logic [31:0]    rsp_header_ff, rsp_header_in;
   logic [31:0]    rsp_status_ff, rsp_status_in;
   logic [31:0]    rsp_buffer_ff, rsp_buffer_in;
   logic           rsp_last_ff, rsp_last_in;

   logic           out_free;
   logic [8:0]     mp9;
   logic [8:0]     sz;
   logic [8:0]     rem_after;
   logic [6:0]     k_plus;
   logic           more_after_setup;
   logic           more_after_data;
   logic [6:0]     idx_ext;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pop       = (state_ff == S_IDLE) && qstat.not_empty;
   assign mp9       = {2'b00, ent_ff.mp};
   assign sz        = (rem_ff < mp9) ? rem_ff : mp9;
   assign rem_after = rem_ff - sz;
   assign k_plus    = {1'b0, k_ff} + 7'd1;
   assign more_after_setup = (rem_ff != 9'd0) && (7'd1 < DATA_LIMIT);
   assign more_after_data  = (rem_after != 9'd0) && (k_plus < DATA_LIMIT);
   assign idx_ext   = {1'b0, rsp_index_ff};

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (qstat.not_empty) state_in = S_SETUP;
         end
         S_SETUP: begin
            if (out_free) state_in = more_after_setup ? S_DATA : S_STATUS;
         end
         S_DATA: begin
            if (out_free) state_in = more_after_data ? S_DATA : S_STATUS;
         end
         S_STATUS: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Working registers and output register
   always_comb begin
      ent_in        = ent_ff;
      k_in          = k_ff;
      rem_in        = rem_ff;
      buf_in        = buf_ff;
      tog_in        = tog_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_index_in  = rsp_index_ff;
      rsp_header_in = rsp_header_ff;
      rsp_status_in = rsp_status_ff;
      rsp_buffer_in = rsp_buffer_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (qstat.not_empty) begin
               ent_in = pop_entry;
               k_in   = 6'd0;
               rem_in = pop_entry.length;
               buf_in = pop_entry.data_buf;
               tog_in = 1'b0;
            end
         end
         S_SETUP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = k_ff;
               rsp_header_in = make_header(PID_SETUP, ent_ff.addr,
                                           11'(SETUP_BYTES - 1), 1'b0);
               rsp_status_in = ent_ff.status;
               rsp_buffer_in = ent_ff.setup_buf;
               rsp_last_in   = 1'b0;
               k_in          = k_plus[5:0];
            end
         end
         S_DATA: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = k_ff;
               rsp_header_in = make_header(ent_ff.data_pid, ent_ff.addr,
                                           {2'b00, sz} - 11'd1, !tog_ff);
               rsp_status_in = ent_ff.status;
               rsp_buffer_in = buf_ff;
               rsp_last_in   = 1'b0;
               k_in          = k_plus[5:0];
               rem_in        = rem_after;
               buf_in        = buf_ff + {23'd0, sz};
               tog_in        = !tog_ff;
            end
         end
         S_STATUS: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = k_ff;
               rsp_header_in = make_header(ent_ff.stat_pid, ent_ff.addr, LEN_ZERO, 1'b1);
               rsp_status_in = ent_ff.status;
               rsp_buffer_in = 32'd0;
               rsp_last_in   = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ent_ff        <= ent_in;
      k_ff          <= k_in;
      rem_ff        <= rem_in;
      buf_ff        <= buf_in;
      tog_ff        <= tog_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_header_ff <= rsp_header_in;
      rsp_status_ff <= rsp_status_in;
      rsp_buffer_ff <= rsp_buffer_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_descriptor_index = rsp_index_ff;
   assign rsp_header_word      = rsp_header_ff;
   assign rsp_status_word      = rsp_status_ff;
   assign rsp_buffer_word      = rsp_buffer_ff;
   assign rsp_last             = rsp_last_ff;

   `ASSERT_PROP(a_data_index_limit, clock, reset, (rsp_valid_ff && !rsp_last_ff) |-> (idx_ext < DATA_LIMIT), "data descriptor past chain limit")
   `ASSERT_PROP(a_first_is_setup, clock, reset, (rsp_valid_ff && (rsp_index_ff == 6'd0)) |-> (rsp_header_ff[7:0] == PID_SETUP), "chain does not open with SETUP")
   `ASSERT_PROP(a_pop_only_idle, clock, reset, pop |=> (state_ff == S_SETUP), "request popped without starting a chain")

endmodule

>>> rtl/control_transfer_descriptor_builder_core.sv
// First descriptor via front, queue, sequencer and output registers; then one per
// cycle while rsp_stall is low. Sequencer steps: idle, SETUP, data per packet,
// status; data packets = ceil(data_length / packet size), max MAX_DESCRIPTORS - 2.
// A two-entry queue lets the front accept requests while the sequencer runs.
// Reset (synchronous): packet size returns to 8, queue and sequencer go empty.
module control_transfer_descriptor_builder_core
   import ctdb_pkg::*;
#(
   parameter int MAX_DESCRIPTORS = 64
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_pkt_size,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [6:0]  req_device_address,
   input  logic        req_low_speed,
   input  logic        req_device_to_host,
   input  logic [8:0]  req_data_length,
   input  logic [31:0] req_setup_buffer_addr,
   input  logic [31:0] req_data_buffer_addr,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_descriptor_index,
   output logic [31:0] rsp_header_word,
   output logic [31:0] rsp_status_word,
   output logic [31:0] rsp_buffer_word,
   output logic        rsp_last
);

   logic [6:0]     pkt_size_ff, pkt_size_in;
   ctdb_qstat_type qstat;
   logic           push, pop;
   ctdb_entry_type push_entry, pop_entry;

   // Packet size register
   assign csr_ready   = 1'b1;
   assign pkt_size_in = (csr_valid && csr_ready) ? csr_pkt_size : pkt_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pkt_size_ff <= 7'd8;
      end else begin
         pkt_size_ff <= pkt_size_in;
      end
   end

   ctdb_front u_front (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_device_address    (req_device_address),
      .req_low_speed         (req_low_speed),
      .req_device_to_host    (req_device_to_host),
      .req_data_length       (req_data_length),
      .req_setup_buffer_addr (req_setup_buffer_addr),
      .req_data_buffer_addr  (req_data_buffer_addr),
      .pkt_size              (pkt_size_ff),
      .qstat                 (qstat),
      .push                  (push),
      .push_entry            (push_entry)
   );

   ctdb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .qstat      (qstat)
   );

   ctdb_back #(
      .MAX_DESCRIPTORS (MAX_DESCRIPTORS)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .qstat                (qstat),
      .pop_entry            (pop_entry),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_descriptor_index (rsp_descriptor_index),
      .rsp_header_word      (rsp_header_word),
      .rsp_status_word      (rsp_status_word),
      .rsp_buffer_word      (rsp_buffer_word),
      .rsp_last             (rsp_last)
   );

endmodule
